FILE: hdl/frqs_pkg.sv
// Shared types and constants for the ready queue scheduler.
package frqs_pkg;

    localparam int DEF_QUEUE_DEPTH = 16;
    localparam int DEF_ID_WIDTH    = 8;

    localparam int OP_W     = 2;
    localparam int TID_W    = 8;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE   = 2'd0,
        OP_YIELD     = 2'd1,
        OP_TERMINATE = 2'd2,
        OP_IGNORED   = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE       = 3'd0,
        STAT_DISPATCHED = 3'd1,
        STAT_TO_DISK    = 3'd2,
        STAT_EMPTY      = 3'd3,
        STAT_FULL       = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_WALK
    } t_state;

    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [TID_W-1:0] dispatched_id;
        logic [CNT_W-1:0] removed_count;
        logic [CNT_W-1:0] queue_count;
    } t_result;

endpackage

FILE: hdl/frqs_mem.sv
// Queue store: one write port, one read port, registered read data.
module frqs_mem #(
    parameter int DEPTH = frqs_pkg::DEF_QUEUE_DEPTH,
    parameter int WIDTH = frqs_pkg::DEF_ID_WIDTH,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/frqs_ctrl.sv
// Queue sequencer: head/count registers, pop and terminate walk over the store.
module frqs_ctrl #(
    parameter int QUEUE_DEPTH = frqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = frqs_pkg::DEF_ID_WIDTH,
    localparam int PW         = $clog2(QUEUE_DEPTH),
    localparam int CW         = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [frqs_pkg::OP_W-1:0]          i_operation,
    input  logic [frqs_pkg::TID_W-1:0]         i_thread_id,
    input  logic                               i_disk_ready,
    output logic                               o_busy,
    output frqs_pkg::t_result                  o_result,
    output logic                               o_mem_we,
    output logic [PW-1:0]                      o_mem_waddr,
    output logic [ID_WIDTH-1:0]                o_mem_wdata,
    output logic [PW-1:0]                      o_mem_raddr,
    input  logic [ID_WIDTH-1:0]                i_mem_rdata
);

    frqs_pkg::t_state  r_state,   n_state;
    logic [PW-1:0]     r_head,    n_head;
    logic [CW-1:0]     r_count,   n_count;
    logic [ID_WIDTH-1:0] r_id,    n_id;
    logic [PW-1:0]     r_chk,     n_chk;
    logic [CW-1:0]     r_kept,    n_kept;
    logic [CW-1:0]     r_removed, n_removed;
    frqs_pkg::t_result r_res,     n_res;

    logic [ID_WIDTH-1:0] w_id;
    logic                w_match;
    logic                w_last;

    // base + off modulo depth; both below depth
    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base,
                                           input logic [PW-1:0] off);
        logic [PW:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= (PW+1)'(QUEUE_DEPTH)) begin
            s = s - (PW+1)'(QUEUE_DEPTH);
        end
        return s[PW-1:0];
    endfunction

    function automatic logic [frqs_pkg::CNT_W-1:0] narrow_cnt(input logic [CW-1:0] v);
        logic [frqs_pkg::CNT_W-1:0] r;
        r = '0;
        for (int b = 0; b < frqs_pkg::CNT_W; b++) begin
            if (b < CW) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    function automatic logic [frqs_pkg::TID_W-1:0] narrow_id(input logic [ID_WIDTH-1:0] v);
        logic [frqs_pkg::TID_W-1:0] r;
        r = '0;
        for (int b = 0; b < frqs_pkg::TID_W; b++) begin
            if (b < ID_WIDTH) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    function automatic logic [ID_WIDTH-1:0] widen_id(input logic [frqs_pkg::TID_W-1:0] v);
        logic [ID_WIDTH-1:0] r;
        r = '0;
        for (int b = 0; b < ID_WIDTH; b++) begin
            if (b < frqs_pkg::TID_W) begin
                r[b] = v[b];
            end
        end
        return r;
    endfunction

    assign w_id    = widen_id(i_thread_id);
    assign w_match = (i_mem_rdata == r_id);
    assign w_last  = ((CW'(r_chk) + CW'(1)) == r_count);

    // control registers reset; walk and result payload registers do not
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= frqs_pkg::S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_res.valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_count     <= n_count;
            r_res.valid <= n_res.valid;
        end
        r_id                <= n_id;
        r_chk               <= n_chk;
        r_kept              <= n_kept;
        r_removed           <= n_removed;
        r_res.status        <= n_res.status;
        r_res.dispatched_id <= n_res.dispatched_id;
        r_res.removed_count <= n_res.removed_count;
        r_res.queue_count   <= n_res.queue_count;
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_count     = r_count;
        n_id        = r_id;
        n_chk       = r_chk;
        n_kept      = r_kept;
        n_removed   = r_removed;
        n_res       = r_res;
        n_res.valid = 1'b0;
        o_mem_we    = 1'b0;
        o_mem_waddr = wrap(r_head, r_count[PW-1:0]);
        o_mem_wdata = w_id;
        o_mem_raddr = r_head;

        case (r_state)
            frqs_pkg::S_IDLE: begin
                if (i_start) begin
                    n_res.valid         = 1'b1;
                    n_res.status        = frqs_pkg::STAT_DONE;
                    n_res.dispatched_id = '0;
                    n_res.removed_count = '0;
                    n_res.queue_count   = narrow_cnt(r_count);
                    case (i_operation)
                        frqs_pkg::OP_ENQUEUE: begin
                            if (r_count >= CW'(QUEUE_DEPTH)) begin
                                n_res.status = frqs_pkg::STAT_FULL;
                            end else begin
                                o_mem_we          = 1'b1;
                                n_count           = r_count + CW'(1);
                                n_res.queue_count = narrow_cnt(r_count + CW'(1));
                            end
                        end
                        frqs_pkg::OP_YIELD: begin
                            if (i_disk_ready) begin
                                n_res.status = frqs_pkg::STAT_TO_DISK;
                            end else if (r_count == '0) begin
                                n_res.status = frqs_pkg::STAT_EMPTY;
                            end else begin
                                // head read issued now, data next cycle
                                n_res.valid = 1'b0;
                                n_state     = frqs_pkg::S_POP;
                            end
                        end
                        frqs_pkg::OP_TERMINATE: begin
                            if (r_count != '0) begin
                                n_res.valid = 1'b0;
                                n_id        = w_id;
                                n_chk       = '0;
                                n_kept      = '0;
                                n_removed   = '0;
                                n_state     = frqs_pkg::S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            frqs_pkg::S_POP: begin
                n_head              = wrap(r_head, PW'(1));
                n_count             = r_count - CW'(1);
                n_res.valid         = 1'b1;
                n_res.status        = frqs_pkg::STAT_DISPATCHED;
                n_res.dispatched_id = narrow_id(i_mem_rdata);
                n_res.removed_count = '0;
                n_res.queue_count   = narrow_cnt(r_count - CW'(1));
                n_state             = frqs_pkg::S_IDLE;
            end
            frqs_pkg::S_WALK: begin
                // compaction writes land at kept <= chk, reads run ahead at chk + 1
                o_mem_waddr = wrap(r_head, r_kept[PW-1:0]);
                o_mem_wdata = i_mem_rdata;
                if (w_match) begin
                    n_removed = r_removed + CW'(1);
                end else begin
                    o_mem_we = 1'b1;
                    n_kept   = r_kept + CW'(1);
                end
                if (!w_last) begin
                    o_mem_raddr = wrap(r_head, r_chk + PW'(1));
                end
                n_chk = r_chk + PW'(1);
                if (w_last) begin
                    n_count             = n_kept;
                    n_res.valid         = 1'b1;
                    n_res.status        = frqs_pkg::STAT_DONE;
                    n_res.dispatched_id = '0;
                    n_res.removed_count = narrow_cnt(n_removed);
                    n_res.queue_count   = narrow_cnt(n_kept);
                    n_state             = frqs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = frqs_pkg::S_IDLE;
            end
        endcase
    end

    assign o_busy   = (r_state != frqs_pkg::S_IDLE);
    assign o_result = r_res;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_pop_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frqs_pkg::S_IDLE && i_start && i_operation == frqs_pkg::OP_YIELD
         && !i_disk_ready && r_count != '0) |=> (r_state == frqs_pkg::S_POP))
        else $error("yield on nonempty queue did not start a pop");

    a_pop_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frqs_pkg::S_POP) |=>
        (r_res.valid && r_res.status == frqs_pkg::STAT_DISPATCHED
         && r_state == frqs_pkg::S_IDLE))
        else $error("pop did not deliver a dispatch");

    a_walk_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == frqs_pkg::S_WALK) |-> ((r_kept + r_removed) == CW'(r_chk)))
        else $error("terminate walk tally mismatch");

    a_removed_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_res.valid && r_res.removed_count != '0) |->
        (r_res.status == frqs_pkg::STAT_DONE))
        else $error("removed count on a non-terminate result");

endmodule

FILE: hdl/fifo_ready_queue_scheduler_top.sv
// Top level of the FIFO thread ready queue scheduler.
//
//  channel   direction  handshake                      payload
//  command   in         start & !busy accepts          i_operation, i_thread_id, i_disk_ready
//  result    out        o_valid, one cycle, no stall   o_status, o_dispatched_id,
//                                                      o_removed_count, o_queue_count
//
// Cycles: enqueue, ignored code, yield to disk, yield on empty and terminate on an
//   empty queue give their result the cycle after acceptance; busy stays low.
// Yield with a pop passes through the pop state: the head entry is read from the queue store,
//   whose read data arrives the cycle after the address.
// Terminate walks the live entries one per cycle through the store's read port,
//   compacting survivors through its write port.
// Reset is synchronous, active low; it clears head and count. The store is not cleared.
// The receiver cannot stall; busy only covers the pop and the terminate walk.
module fifo_ready_queue_scheduler_top #(
    parameter int QUEUE_DEPTH = frqs_pkg::DEF_QUEUE_DEPTH,
    parameter int ID_WIDTH    = frqs_pkg::DEF_ID_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [frqs_pkg::OP_W-1:0]         i_operation,
    input  logic [frqs_pkg::TID_W-1:0]        i_thread_id,
    input  logic                              i_disk_ready,
    output logic                              o_valid,
    output logic [frqs_pkg::STATUS_W-1:0]     o_status,
    output logic [frqs_pkg::TID_W-1:0]        o_dispatched_id,
    output logic [frqs_pkg::CNT_W-1:0]        o_removed_count,
    output logic [frqs_pkg::CNT_W-1:0]        o_queue_count
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    frqs_pkg::t_result   w_result;
    logic                w_mem_we;
    logic [PW-1:0]       w_mem_waddr;
    logic [ID_WIDTH-1:0] w_mem_wdata;
    logic [PW-1:0]       w_mem_raddr;
    logic [ID_WIDTH-1:0] w_mem_rdata;

    // sequencer owns all control; store holds the queued thread IDs
    frqs_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_WIDTH    (ID_WIDTH)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_operation  (i_operation),
        .i_thread_id  (i_thread_id),
        .i_disk_ready (i_disk_ready),
        .o_busy       (busy),
        .o_result     (w_result),
        .o_mem_we     (w_mem_we),
        .o_mem_waddr  (w_mem_waddr),
        .o_mem_wdata  (w_mem_wdata),
        .o_mem_raddr  (w_mem_raddr),
        .i_mem_rdata  (w_mem_rdata)
    );

    frqs_mem #(
        .DEPTH (QUEUE_DEPTH),
        .WIDTH (ID_WIDTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    // one result transaction per accepted command, shown for a single cycle
    assign o_valid         = w_result.valid;
    assign o_status        = w_result.status;
    assign o_dispatched_id = w_result.dispatched_id;
    assign o_removed_count = w_result.removed_count;
    assign o_queue_count   = w_result.queue_count;

endmodule

FILE: tb/fifo_ready_queue_scheduler_top_tb.sv
// Self-checking testbench for the FIFO thread ready queue scheduler.
`timescale 1ns / 100ps

module fifo_ready_queue_scheduler_top_tb;

    // Queue geometry follows the block's defaults.
    localparam int QDEPTH       = frqs_pkg::DEF_QUEUE_DEPTH;
    localparam int RANDOM_ITEMS = 700;
    // Once this many random transactions remain, the sender stops idling.
    localparam int QUIET_TAIL   = 150;
    // Longest terminate walk plus pipeline slack.
    localparam int DRAIN_CYCLES = QDEPTH + 8;
    // Slowest run is roughly 730 transactions, each a full terminate walk plus the longest idle gap.
    // Allow several times that.
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_REPORTS  = 10;

    // One scheduler answer, as the result ports carry it.
    typedef struct {
        frqs_pkg::t_status          status;
        logic [frqs_pkg::TID_W-1:0] dispatched_id;
        logic [frqs_pkg::CNT_W-1:0] removed_count;
        logic [frqs_pkg::CNT_W-1:0] queue_count;
    } t_sched_answer;

    // DUT connections; every input is known from time zero.
    logic                          i_clk           = 1'b0;
    logic                          i_rst_n         = 1'b0;
    logic                          start           = 1'b0;
    logic [frqs_pkg::OP_W-1:0]     i_operation     = '0;
    logic [frqs_pkg::TID_W-1:0]    i_thread_id     = '0;
    logic                          i_disk_ready    = 1'b0;
    logic                          busy;
    logic                          o_valid;
    logic [frqs_pkg::STATUS_W-1:0] o_status;
    logic [frqs_pkg::TID_W-1:0]    o_dispatched_id;
    logic [frqs_pkg::CNT_W-1:0]    o_removed_count;
    logic [frqs_pkg::CNT_W-1:0]    o_queue_count;

    // Shadow copy of the ready queue: circular store, head and live count.
    logic [frqs_pkg::TID_W-1:0]   ring [QDEPTH];
    int unsigned        ring_head;
    int unsigned        live_count;

    // Answers predicted for accepted transactions, oldest first.
    t_sched_answer      pending_answers [$];

    int unsigned        cycle_count;
    int unsigned        fail_count;
    int unsigned        report_count;
    int unsigned        random_sent;
    int unsigned        idle_pct;

    // Coverage tallies for the closing summary.
    int unsigned        n_transactions;
    int unsigned        n_dispatched;
    int unsigned        n_to_disk;
    int unsigned        n_empty;
    int unsigned        n_full;
    int unsigned        n_terminates;
    int unsigned        max_removed;

    always #6 i_clk = ~i_clk;

    fifo_ready_queue_scheduler_top u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_operation     (i_operation),
        .i_thread_id     (i_thread_id),
        .i_disk_ready    (i_disk_ready),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_dispatched_id (o_dispatched_id),
        .o_removed_count (o_removed_count),
        .o_queue_count   (o_queue_count)
    );

    // Apply one accepted command to the shadow queue and return the answer the
    // block must give for it.
    function automatic t_sched_answer ready_queue_step(frqs_pkg::t_op op,
                                                       logic [frqs_pkg::TID_W-1:0] tid,
                                                       logic disk);
        t_sched_answer ans;
        int unsigned   kept;
        logic [frqs_pkg::TID_W-1:0] entry;
        ans.status        = frqs_pkg::STAT_DONE;
        ans.dispatched_id = '0;
        ans.removed_count = '0;
        case (op)
            frqs_pkg::OP_ENQUEUE: begin
                if (live_count >= QDEPTH) begin
                    ans.status = frqs_pkg::STAT_FULL;     // dropped, state untouched
                end else begin
                    ring[(ring_head + live_count) % QDEPTH] = tid;
                    live_count++;
                end
            end
            frqs_pkg::OP_YIELD: begin
                // Disk flag wins over the ready queue, even when it holds entries.
                if (disk) begin
                    ans.status = frqs_pkg::STAT_TO_DISK;
                end else if (live_count == 0) begin
                    ans.status = frqs_pkg::STAT_EMPTY;
                end else begin
                    ans.status        = frqs_pkg::STAT_DISPATCHED;
                    ans.dispatched_id = ring[ring_head];
                    ring_head         = (ring_head + 1) % QDEPTH;
                    live_count--;
                end
            end
            frqs_pkg::OP_TERMINATE: begin
                // Remove every match; survivors slide toward the head in order.
                kept = 0;
                for (int i = 0; i < live_count; i++) begin
                    entry = ring[(ring_head + i) % QDEPTH];
                    if (entry == tid) begin
                        ans.removed_count++;
                    end else begin
                        ring[(ring_head + kept) % QDEPTH] = entry;
                        kept++;
                    end
                end
                live_count = kept;
            end
            default: ;  // unused code: answered, nothing changes
        endcase
        ans.queue_count = frqs_pkg::CNT_W'(live_count);
        return ans;
    endfunction

    // Present one command and hold it until the block takes it. Returns at the
    // accepting edge with start still high, so back-to-back commands need no
    // extra edge.
    task automatic send_command(frqs_pkg::t_op op, logic [frqs_pkg::TID_W-1:0] tid,
                                logic disk);
        t_sched_answer ans;
        start        <= 1'b1;
        i_operation  <= op;
        i_thread_id  <= tid;
        i_disk_ready <= disk;
        do @(posedge i_clk); while (busy);
        ans = ready_queue_step(op, tid, disk);
        pending_answers.push_back(ans);
        n_transactions++;
        case (ans.status)
            frqs_pkg::STAT_DISPATCHED: n_dispatched++;
            frqs_pkg::STAT_TO_DISK:    n_to_disk++;
            frqs_pkg::STAT_EMPTY:      n_empty++;
            frqs_pkg::STAT_FULL:       n_full++;
            default: ;
        endcase
        if (op == frqs_pkg::OP_TERMINATE) begin
            n_terminates++;
            if (32'(ans.removed_count) > max_removed)
                max_removed = 32'(ans.removed_count);
        end
    endtask

    // Sender-side idling: with probability idle_pct drop start for a random gap.
    // Payload pins carry junk meanwhile; the block must ignore it.
    task automatic maybe_idle();
        int unsigned gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 13);
            start        <= 1'b0;
            i_operation  <= frqs_pkg::OP_W'($urandom_range(0, 3));
            i_thread_id  <= frqs_pkg::TID_W'($urandom_range(0, 255));
            i_disk_ready <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Empty-queue corner cases: yield with nothing queued, yield diverted to the
    // disk queue, terminate with nothing to remove, and the unused op code.
    task automatic test_empty_queue();
        send_command(frqs_pkg::OP_YIELD, 8'h00, 1'b0);
        maybe_idle();
        send_command(frqs_pkg::OP_YIELD, 8'hFF, 1'b1);
        maybe_idle();
        send_command(frqs_pkg::OP_TERMINATE, 8'h12, 1'b0);
        maybe_idle();
        send_command(frqs_pkg::OP_IGNORED, 8'hFF, 1'b1);
        maybe_idle();
    endtask

    // Fill to capacity with the ID extremes and alternating bit patterns, then
    // overflow: the extra enqueue must be dropped as full.
    task automatic test_fill_to_overflow();
        logic [frqs_pkg::TID_W-1:0] pattern [4] = '{8'h00, 8'hFF, 8'h55, 8'hAA};
        for (int i = 0; i < QDEPTH; i++) begin
            send_command(frqs_pkg::OP_ENQUEUE, pattern[i % 4], 1'b0);
            maybe_idle();
        end
        send_command(frqs_pkg::OP_ENQUEUE, 8'h33, 1'b0);
        maybe_idle();
        send_command(frqs_pkg::OP_IGNORED, 8'h00, 1'b0);
        maybe_idle();
    endtask

    // Terminate with several matches and with none, then dispatch decisions on
    // a nonempty queue: disk first, then a real pop.
    task automatic test_terminate_and_dispatch();
        send_command(frqs_pkg::OP_TERMINATE, 8'hFF, 1'b1);
        maybe_idle();
        send_command(frqs_pkg::OP_TERMINATE, 8'h77, 1'b0);
        maybe_idle();
        send_command(frqs_pkg::OP_YIELD, 8'hAA, 1'b1);
        maybe_idle();
        send_command(frqs_pkg::OP_YIELD, 8'h55, 1'b0);
        maybe_idle();
    endtask

    // Random traffic in bursts. Each burst has its own fill bias, a small pool of
    // IDs so terminates find duplicates (a pool of one can fill the whole queue
    // with one ID), its own disk-ready rate and its own idle rate.
    task automatic test_random_traffic();
        int unsigned      burst_len;
        int unsigned      enq_weight;
        int unsigned      disk_pct;
        int unsigned      pool_size;
        int unsigned      pick;
        logic [frqs_pkg::TID_W-1:0] id_pool [4];
        frqs_pkg::t_op              op;
        logic [frqs_pkg::TID_W-1:0] tid;
        while (random_sent < RANDOM_ITEMS) begin
            burst_len = $urandom_range(10, 40);
            case ($urandom_range(0, 2))
                0: enq_weight = 75;
                1: enq_weight = 45;
                default: enq_weight = 20;
            endcase
            case ($urandom_range(0, 2))
                0: disk_pct = 0;
                1: disk_pct = 20;
                default: disk_pct = 60;
            endcase
            pool_size = $urandom_range(1, 4);
            foreach (id_pool[k])
                id_pool[k] = frqs_pkg::TID_W'($urandom_range(0, 255));
            if (random_sent + QUIET_TAIL >= RANDOM_ITEMS) begin
                idle_pct = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 40;
                endcase
            end
            for (int n = 0; n < burst_len && random_sent < RANDOM_ITEMS; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    op = frqs_pkg::OP_IGNORED;
                else if (pick < 3 + enq_weight)
                    op = frqs_pkg::OP_ENQUEUE;
                else if ($urandom_range(0, 99) < 65)
                    op = frqs_pkg::OP_YIELD;
                else
                    op = frqs_pkg::OP_TERMINATE;
                if ($urandom_range(0, 99) < 80)
                    tid = id_pool[$urandom_range(0, pool_size - 1)];
                else
                    tid = frqs_pkg::TID_W'($urandom_range(0, 255));
                send_command(op, tid, $urandom_range(0, 99) < disk_pct);
                random_sent++;
                if (random_sent + QUIET_TAIL >= RANDOM_ITEMS)
                    idle_pct = 0;
                maybe_idle();
            end
        end
    endtask

    // Result checker: every strobed answer is matched against the oldest
    // prediction. The block cannot be stalled, so this only observes.
    always @(posedge i_clk) begin
        t_sched_answer want;
        if (i_rst_n && o_valid) begin
            if (pending_answers.size() == 0) begin
                fail_count++;
                if (report_count < MAX_REPORTS) begin
                    report_count++;
                    $display("[%0t] unexpected answer: st %0d id %02h rm %0d cnt %0d",
                             $realtime, o_status, o_dispatched_id, o_removed_count,
                             o_queue_count);
                end
            end else begin
                want = pending_answers.pop_front();
                if (o_status !== want.status || o_dispatched_id !== want.dispatched_id ||
                    o_removed_count !== want.removed_count ||
                    o_queue_count !== want.queue_count) begin
                    fail_count++;
                    if (report_count < MAX_REPORTS) begin
                        report_count++;
                        $display("[%0t] exp/act st %0d/%0d id %h/%h rm %0d/%0d cnt %0d/%0d",
                                 $realtime, want.status, o_status,
                                 want.dispatched_id, o_dispatched_id,
                                 want.removed_count, o_removed_count,
                                 want.queue_count, o_queue_count);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake or a lost answer ends here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d answers outstanding",
                     cycle_count, pending_answers.size());
            $display("fifo_ready_queue_scheduler_top_tb NOT OK");
            $finish;
        end
    end

    initial begin
        // Shadow state matches the block's reset: empty queue, head at zero.
        ring_head  = 0;
        live_count = 0;
        idle_pct   = 25;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_to_overflow();
        test_terminate_and_dispatch();
        test_random_traffic();

        // Stop offering work, let every answer come home, then give any stray
        // extra answer time to show up.
        start <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d transactions: %0d pops, %0d disk diversions, %0d empty yields",
                 n_transactions, n_dispatched, n_to_disk, n_empty);
        $display("  %0d full drops, %0d terminates removing up to %0d entries, %0d failures",
                 n_full, n_terminates, max_removed, fail_count);
        if (fail_count == 0)
            $display("fifo_ready_queue_scheduler_top_tb OK");
        else
            $display("fifo_ready_queue_scheduler_top_tb NOT OK");
        $finish;
    end

endmodule
